// ===== src/otgs_pkg.sv =====
`timescale 1ns / 1ps

package otgs_pkg;

	// Configuration register indexes
	typedef enum logic [0:0] {
		REG_DEVICE_ADDRESS = 1'b0,
		REG_WRAP_THRESHOLD = 1'b1
	} reg_index_t;

	localparam logic [7:0] DEVICE_ADDRESS_RESET = 8'd120;
	localparam logic [7:0] WRAP_THRESHOLD_RESET = 8'd123;

	// Message control bytes
	localparam logic [6:0] CTRL_CMD  = 7'h00;
	localparam logic [6:0] CTRL_DATA = 7'h40;

	// Controller command codes
	localparam logic [7:0] CMD_ADDR_MODE = 8'h20;
	localparam logic [7:0] ADDR_MODE_PAGE = 8'h02;
	localparam logic [7:0] CMD_PAGE_BASE = 8'hB0;
	localparam logic [7:0] CMD_COL_HI_BASE = 8'h10;
	localparam logic [7:0] COL_LO_MASK = 8'h0F;

	localparam logic [7:0] FIRST_CODE   = 8'd32;
	localparam logic [7:0] CHAR_ADVANCE = 8'd6;

	// Font layout: one row per glyph, column 0 in the top byte
	localparam int FONT_GLYPHS = 95;
	localparam int FONT_STRIDE = 5;
	localparam int FONT_IDX_W  = $clog2(FONT_GLYPHS);
	localparam int FONT_COL_W  = 3;

	typedef logic [FONT_STRIDE*8-1:0] glyph_row_t;

	localparam glyph_row_t FONT_ROM [FONT_GLYPHS] = '{
		40'h0000000000, 40'h00005F0000, 40'h0007000700, 40'h147F147F14, 40'h242A7F2A12,
		40'h2313086462, 40'h3649562050, 40'h0008070300, 40'h001C224100, 40'h0041221C00,
		40'h2A1C7F1C2A, 40'h08083E0808, 40'h0000703000, 40'h0808080808, 40'h0000606000,
		40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h7249494946, 40'h2141494D33,
		40'h1814127F10, 40'h2745454539, 40'h3C4A494931, 40'h4121110907, 40'h3649494936,
		40'h464949291E, 40'h0000140000, 40'h0040340000, 40'h0008142241, 40'h1414141414,
		40'h0041221408, 40'h0201590906, 40'h3E415D594E, 40'h7C1211127C, 40'h7F49494936,
		40'h3E41414122, 40'h7F4141413E, 40'h7F49494941, 40'h7F09090901, 40'h3E41415173,
		40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
		40'h7F021C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
		40'h7F09192946, 40'h2649494932, 40'h03017F0103, 40'h3F4040403F, 40'h1F2040201F,
		40'h3F4038403F, 40'h6314081463, 40'h0304780403, 40'h6159494D43, 40'h007F414141,
		40'h0204081020, 40'h004141417F, 40'h0402010204, 40'h4040404040, 40'h0003070800,
		40'h2054543840, 40'h7F28444438, 40'h3844444428, 40'h384444287F, 40'h3854545418,
		40'h00087E0902, 40'h0C52524A3C, 40'h7F08040478, 40'h00447D4000, 40'h2040403D00,
		40'h7F10284400, 40'h00417F4000, 40'h7C04780478, 40'h7C08040478, 40'h3844444438,
		40'h7C18242418, 40'h182424187C, 40'h7C08040408, 40'h4854545424, 40'h04043F4424,
		40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h4C5050503C,
		40'h4464544C44, 40'h0008364100, 40'h0000770000, 40'h0041360800, 40'h0201020402
	};

	// One queued character: where to draw and which glyph
	typedef struct packed {
		logic [7:0]            column;
		logic [2:0]            page;
		logic [FONT_IDX_W-1:0] rom_idx;
		logic                  blank;
	} char_entry_t;

	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

	// Queue status seen by the two sides
	typedef struct packed {
		logic full;
		logic empty;
	} queue_status_t;

	// Pick one glyph column byte; columns past the stored ones are blank
	function automatic logic [7:0] glyph_column(glyph_row_t row, logic [FONT_COL_W-1:0] col);
		logic [7:0] b;
		b = 8'h00;
		for (int c = 0; c < FONT_STRIDE; c++) begin
			if (int'(col) == c) begin
				b = row[(FONT_STRIDE-1-c)*8 +: 8];
			end
		end
		return b;
	endfunction

endpackage

// ===== src/otgs_if.sv =====
`timescale 1ns / 1ps

// Character channel
interface otgs_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       new_string;
	logic [6:0] start_column;
	logic [2:0] start_page;

	modport source(output valid, char_code, new_string, start_column, start_page,
		input ready);
	modport sink(input valid, char_code, new_string, start_column, start_page,
		output ready);
endinterface

// Message channel
interface otgs_msg_if;
	logic       valid;
	logic       ready;
	logic [7:0] target_address;
	logic [6:0] control_byte;
	logic [7:0] payload;
	logic       last_of_char;

	modport source(output valid, target_address, control_byte, payload, last_of_char,
		input ready);
	modport sink(input valid, target_address, control_byte, payload, last_of_char,
		output ready);
endinterface

// ===== src/otgs_queue.sv =====
`timescale 1ns / 1ps

module otgs_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  otgs_pkg::char_entry_t  push_entry,
	input  logic                   pop,
	output otgs_pkg::char_entry_t  head,
	output otgs_pkg::queue_status_t status
);

	localparam int DEPTH = otgs_pkg::QUEUE_DEPTH;
	localparam int PTR_W = otgs_pkg::QUEUE_PTR_W;

	otgs_pkg::char_entry_t mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [PTR_W:0]   count_q;
	logic             do_push;
	logic             do_pop;

	always_comb begin
		status.full  = (count_q == (PTR_W+1)'(DEPTH));
		status.empty = (count_q == '0);
		do_push      = push && !status.full;
		do_pop       = pop && !status.empty;
		head         = mem_q[rd_ptr_q];
	end

	// Advance pointers and count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

endmodule

// ===== src/otgs_front.sv =====
`timescale 1ns / 1ps

module otgs_front #(
	parameter int GLYPH_COUNT = 95
) (
	input  logic                    clk,
	input  logic                    arst_n,
	otgs_char_if.sink               chars,
	input  logic [7:0]              wrap_threshold,
	input  otgs_pkg::queue_status_t q_status,
	output logic                    push,
	output otgs_pkg::char_entry_t   push_entry
);

	logic [7:0] cursor_column_q;
	logic [2:0] cursor_page_q;
	logic [7:0] col_eff;
	logic [2:0] page_eff;
	logic       wrap;
	logic [7:0] glyph_idx;
	logic       blank;

	assign chars.ready = !q_status.full;
	assign push        = chars.valid && !q_status.full;

	// Classify the character and resolve its cursor
	always_comb begin
		col_eff   = chars.new_string ? {1'b0, chars.start_column} : cursor_column_q;
		page_eff  = chars.new_string ? chars.start_page : cursor_page_q;
		wrap      = (col_eff >= wrap_threshold);
		glyph_idx = chars.char_code - otgs_pkg::FIRST_CODE;
		blank     = (chars.char_code < otgs_pkg::FIRST_CODE)
			|| ({1'b0, glyph_idx} >= 9'(GLYPH_COUNT))
			|| ({1'b0, glyph_idx} >= 9'(otgs_pkg::FONT_GLYPHS));

		push_entry.column  = col_eff;
		push_entry.page    = page_eff;
		push_entry.blank   = blank;
		push_entry.rom_idx = blank ? '0 : glyph_idx[otgs_pkg::FONT_IDX_W-1:0];
	end

	// Advance the cursor past each accepted item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_column_q <= '0;
			cursor_page_q   <= '0;
		end else if (push) begin
			cursor_page_q   <= wrap ? page_eff + 3'd1 : page_eff;
			cursor_column_q <= (wrap ? 8'd0 : col_eff) + otgs_pkg::CHAR_ADVANCE;
		end
	end

endmodule

// ===== src/otgs_back.sv =====
`timescale 1ns / 1ps

module otgs_back #(
	parameter int GLYPH_WIDTH = 5
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic [7:0]              device_address,
	input  otgs_pkg::char_entry_t   head,
	input  otgs_pkg::queue_status_t q_status,
	output logic                    pop,
	otgs_msg_if.source              msgs
);

	localparam int CNT_W = (GLYPH_WIDTH > 1) ? $clog2(GLYPH_WIDTH) : 1;

	typedef enum logic [5:0] {
		ST_MODE     = 6'b000001,
		ST_MODE_ARG = 6'b000010,
		ST_PAGE     = 6'b000100,
		ST_COL_LO   = 6'b001000,
		ST_COL_HI   = 6'b010000,
		ST_DATA     = 6'b100000
	} msg_state_t;

	msg_state_t             state_q;
	msg_state_t             state_next;
	logic                   busy_q;
	logic [CNT_W-1:0]       col_cnt_q;
	logic [7:0]             col_base_q;
	logic [2:0]             page_q;
	otgs_pkg::glyph_row_t   row_q;
	logic                   out_valid_q;
	logic [7:0]             out_addr_q;
	logic [6:0]             out_ctrl_q;
	logic [7:0]             out_payload_q;
	logic                   out_last_q;
	logic                   step;
	logic                   is_last;
	logic                   load;
	logic [7:0]             col_addr;
	logic [6:0]             msg_ctrl;
	logic [7:0]             msg_payload;

	assign msgs.valid          = out_valid_q;
	assign msgs.target_address = out_addr_q;
	assign msgs.control_byte   = out_ctrl_q;
	assign msgs.payload        = out_payload_q;
	assign msgs.last_of_char   = out_last_q;

	// Build the current message and decide whether to step
	always_comb begin
		step     = busy_q && (!out_valid_q || msgs.ready);
		is_last  = (state_q == ST_DATA) && (col_cnt_q == CNT_W'(GLYPH_WIDTH-1));
		load     = !q_status.empty && (!busy_q || (step && is_last));
		pop      = load;
		col_addr = col_base_q + 8'(col_cnt_q);

		unique case (state_q)
			ST_MODE: begin
				msg_ctrl    = otgs_pkg::CTRL_CMD;
				msg_payload = otgs_pkg::CMD_ADDR_MODE;
				state_next  = ST_MODE_ARG;
			end
			ST_MODE_ARG: begin
				msg_ctrl    = otgs_pkg::CTRL_CMD;
				msg_payload = otgs_pkg::ADDR_MODE_PAGE;
				state_next  = ST_PAGE;
			end
			ST_PAGE: begin
				msg_ctrl    = otgs_pkg::CTRL_CMD;
				msg_payload = otgs_pkg::CMD_PAGE_BASE + {5'd0, page_q};
				state_next  = ST_COL_LO;
			end
			ST_COL_LO: begin
				msg_ctrl    = otgs_pkg::CTRL_CMD;
				msg_payload = col_addr & otgs_pkg::COL_LO_MASK;
				state_next  = ST_COL_HI;
			end
			ST_COL_HI: begin
				msg_ctrl    = otgs_pkg::CTRL_CMD;
				msg_payload = otgs_pkg::CMD_COL_HI_BASE + {4'd0, col_addr[7:4]};
				state_next  = ST_DATA;
			end
			ST_DATA: begin
				msg_ctrl    = otgs_pkg::CTRL_DATA;
				msg_payload = otgs_pkg::glyph_column(row_q,
					otgs_pkg::FONT_COL_W'(col_cnt_q));
				state_next  = ST_MODE;
			end
			default: begin
				msg_ctrl    = otgs_pkg::CTRL_CMD;
				msg_payload = 8'h00;
				state_next  = ST_MODE;
			end
		endcase
	end

	// Sequence messages and hold the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			state_q     <= ST_MODE;
			col_cnt_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				busy_q    <= 1'b1;
				state_q   <= ST_MODE;
				col_cnt_q <= '0;
			end else if (step) begin
				if (is_last) begin
					busy_q <= 1'b0;
				end
				state_q <= state_next;
				if (state_q == ST_DATA) begin
					col_cnt_q <= col_cnt_q + 1'b1;
				end
			end
			if (step) begin
				out_valid_q <= 1'b1;
			end else if (msgs.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Load character data and message payload
	always_ff @(posedge clk) begin
		if (load) begin
			col_base_q <= head.column;
			page_q     <= head.page;
			row_q      <= head.blank ? '0 : otgs_pkg::FONT_ROM[head.rom_idx];
		end
		if (step) begin
			out_addr_q    <= device_address;
			out_ctrl_q    <= msg_ctrl;
			out_payload_q <= msg_payload;
			out_last_q    <= is_last;
		end
	end

	a_load_starts_glyph: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> busy_q && (state_q == ST_MODE) && (col_cnt_q == '0))
		else $error("character load did not restart the sequence");

	a_last_frees: assert property (@(posedge clk) disable iff (!arst_n)
		step && is_last && !load |=> !busy_q)
		else $error("sequencer stayed busy after the final message");

	a_data_ctrl: assert property (@(posedge clk) disable iff (!arst_n)
		step && (state_q == ST_DATA) |=> msgs.valid
			&& (msgs.control_byte == otgs_pkg::CTRL_DATA))
		else $error("data message left without data control byte");

endmodule

// ===== src/oled_text_glyph_streamer_unit.sv =====
`timescale 1ns / 1ps

// Text glyph streamer: each character item becomes 6 * GLYPH_WIDTH two-byte
// messages (30 with the default width) that draw its 5x7 glyph at the text
// cursor: for every glyph column the page-mode, page and column-address
// commands, then the glyph data byte. The message sequencer issues one
// message per clock while msgs.ready does not stall the output; an item
// taken while idle passes through the queue and the sequencer's load
// registers before its first message reaches the output register. A
// two-entry queue between the cursor stage and the sequencer lets new
// characters be taken while earlier ones are still being sent. Codes
// outside space..tilde draw a blank glyph. Write device_address and
// wrap_threshold only while no character is in flight.
module oled_text_glyph_streamer_unit #(
	parameter int GLYPH_WIDTH = 5,
	parameter int GLYPH_COUNT = 95
) (
	input  logic       clk,
	input  logic       arst_n,
	otgs_char_if.sink  chars,
	otgs_msg_if.source msgs,
	input  logic       cfg_we,
	input  logic [0:0] cfg_index,
	input  logic [7:0] cfg_wdata
);

	logic [7:0]              device_address_q;
	logic [7:0]              wrap_threshold_q;
	logic                    push;
	logic                    pop;
	otgs_pkg::char_entry_t   push_entry;
	otgs_pkg::char_entry_t   head;
	otgs_pkg::queue_status_t q_status;

	// Hold configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			device_address_q <= otgs_pkg::DEVICE_ADDRESS_RESET;
			wrap_threshold_q <= otgs_pkg::WRAP_THRESHOLD_RESET;
		end else if (cfg_we) begin
			unique case (otgs_pkg::reg_index_t'(cfg_index))
				otgs_pkg::REG_DEVICE_ADDRESS: device_address_q <= cfg_wdata;
				otgs_pkg::REG_WRAP_THRESHOLD: wrap_threshold_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	otgs_front #(
		.GLYPH_COUNT(GLYPH_COUNT)
	) u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.chars         (chars),
		.wrap_threshold(wrap_threshold_q),
		.q_status      (q_status),
		.push          (push),
		.push_entry    (push_entry)
	);

	otgs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	otgs_back #(
		.GLYPH_WIDTH(GLYPH_WIDTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.device_address(device_address_q),
		.head          (head),
		.q_status      (q_status),
		.pop           (pop),
		.msgs          (msgs)
	);

endmodule
